// File: rtl/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// Shared sizes, codes and types of the page replacement tracker.
// ----------------------------------------------------------------------------
package prt_pkg;

  // sizes
  localparam int SLOTS   = 16;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int PAGE_W  = 20;
  localparam int SPACE_W = 8;
  localparam int STAMP_W = 32;
  localparam int SLOT_W  = 4;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 3;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TOUCH  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_INS_FREE  = 3'd0,
    ST_INS_EVICT = 3'd1,
    ST_TOUCHED   = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NO_MATCH  = 3'd4
  } status_t;

  // operating mode of the shared compare unit
  typedef enum logic [1:0] {
    CMP_MATCH = 2'd0,
    CMP_LIFO  = 2'd1,
    CMP_FIFO  = 2'd2
  } cmp_mode_t;

  // one update of the slot store
  typedef struct packed {
    logic               ins;      // fill slot: used, accessed clear, new stamp
    logic               restamp;  // second chance: accessed clear, new stamp
    logic               touch;    // set accessed
    logic               drop;     // free slot
    logic [IDX_W-1:0]   idx;
    logic [STAMP_W-1:0] stamp;
  } store_op_t;

endpackage

// File: rtl/prt_cmp_unit.sv
// ----------------------------------------------------------------------------
// prt_cmp_unit
// Shared compare unit: page match, or stamp order against the best so far.
// ----------------------------------------------------------------------------
module prt_cmp_unit (
  input  prt_pkg::cmp_mode_t            mode,
  input  logic                          entry_used,
  input  logic [prt_pkg::STAMP_W-1:0]   entry_stamp,
  input  logic [prt_pkg::STAMP_W-1:0]   best_stamp,
  input  logic                          found,
  input  logic [prt_pkg::PAGE_W-1:0]    entry_page,
  input  logic [prt_pkg::SPACE_W-1:0]   entry_space,
  input  logic [prt_pkg::PAGE_W-1:0]    key_page,
  input  logic [prt_pkg::SPACE_W-1:0]   key_space,
  output logic                          take
);
  import prt_pkg::*;

  logic better;

  // pick the ordering: LIFO wants strictly larger, FIFO smaller or equal
  always_comb begin
    case (mode)
      CMP_LIFO: better = !found || (entry_stamp > best_stamp);
      CMP_FIFO: better = !found || (entry_stamp <= best_stamp);
      CMP_MATCH: better = (entry_page == key_page) && (entry_space == key_space);
      default: better = 1'b0;
    endcase
  end

  assign take = entry_used && better;

endmodule

// File: rtl/prt_slot_store.sv
// ----------------------------------------------------------------------------
// prt_slot_store
// Slot table: used and accessed flags, page, space id and stamp per slot.
// ----------------------------------------------------------------------------
module prt_slot_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  prt_pkg::store_op_t            op,
  input  logic [prt_pkg::PAGE_W-1:0]    wr_page,
  input  logic [prt_pkg::SPACE_W-1:0]   wr_space,
  input  logic [prt_pkg::IDX_W-1:0]     rd_idx,
  output logic [prt_pkg::PAGE_W-1:0]    rd_page,
  output logic [prt_pkg::SPACE_W-1:0]   rd_space,
  output logic [prt_pkg::STAMP_W-1:0]   rd_stamp,
  output logic [prt_pkg::SLOTS-1:0]     used,
  output logic [prt_pkg::SLOTS-1:0]     accessed
);
  import prt_pkg::*;

  logic [PAGE_W-1:0]  slot_page_r  [SLOTS];
  logic [SPACE_W-1:0] slot_space_r [SLOTS];
  logic [STAMP_W-1:0] slot_stamp_r [SLOTS];
  logic [SLOTS-1:0]   used_r;
  logic [SLOTS-1:0]   accessed_r;
  logic [PAGE_W-1:0]  rd_page_r;
  logic [SPACE_W-1:0] rd_space_r;
  logic [STAMP_W-1:0] rd_stamp_r;

  // write payload of a filled or restamped slot, register the read word
  always_ff @(posedge clk) begin
    if (op.ins) begin
      slot_page_r[op.idx]  <= wr_page;
      slot_space_r[op.idx] <= wr_space;
    end
    if (op.ins || op.restamp) begin
      slot_stamp_r[op.idx] <= op.stamp;
    end
    rd_page_r  <= slot_page_r[rd_idx];
    rd_space_r <= slot_space_r[rd_idx];
    // pass a stamp written at the same edge straight to the read word
    if ((op.ins || op.restamp) && (op.idx == rd_idx)) begin
      rd_stamp_r <= op.stamp;
    end else begin
      rd_stamp_r <= slot_stamp_r[rd_idx];
    end
  end

  // update flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      accessed_r <= '0;
    end else begin
      if (op.ins) begin
        used_r[op.idx]     <= 1'b1;
        accessed_r[op.idx] <= 1'b0;
      end
      if (op.restamp) begin
        accessed_r[op.idx] <= 1'b0;
      end
      if (op.touch) begin
        accessed_r[op.idx] <= 1'b1;
      end
      if (op.drop) begin
        used_r[op.idx]     <= 1'b0;
        accessed_r[op.idx] <= 1'b0;
      end
    end
  end

  // single registered read port, addressed the cycle before its word is read
  assign rd_page  = rd_page_r;
  assign rd_space = rd_space_r;
  assign rd_stamp = rd_stamp_r;
  assign used     = used_r;
  assign accessed = accessed_r;

endmodule

// File: rtl/page_replacement_tracker_top.sv
// ----------------------------------------------------------------------------
// page_replacement_tracker_top
// Resident page tracker with LIFO or second-chance FIFO victim choice.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | words
//  in_     | input     | in_valid / in_stall  | command, page number, space id
//  out_    | output    | out_valid / out_stall| status, slot, evicted page/space
//  cfg_    | input     | cfg_valid / cfg_ready| policy bit (cfg_data)
//
//  Insert into a free slot and an unknown command go straight to the result;
//  touch and remove scan every slot; a LIFO eviction scans once, then evicts;
//  a FIFO eviction scans again after each second chance given, at most SLOTS.
//  Each round scans one slot per cycle through the single store read port and
//  the shared compare unit. Input stalls from accept until the result is
//  staged. Reset clears all slots and the stamp counter and sets policy FIFO.
//  A waiting result holds the sequencer only if the output is still stalled.
// ----------------------------------------------------------------------------
module page_replacement_tracker_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [prt_pkg::CMD_W-1:0]     in_command,
  input  logic [prt_pkg::PAGE_W-1:0]    in_page_number,
  input  logic [prt_pkg::SPACE_W-1:0]   in_space_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [prt_pkg::STAT_W-1:0]    out_status,
  output logic [prt_pkg::SLOT_W-1:0]    out_slot,
  output logic [prt_pkg::PAGE_W-1:0]    out_evicted_page,
  output logic [prt_pkg::SPACE_W-1:0]   out_evicted_space,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [0:0]                    cfg_data
);
  import prt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN, S_CHECK, S_EVICT, S_RESP
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  state_t             state_r, state_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [PAGE_W-1:0]  page_r, page_nxt;
  logic [SPACE_W-1:0] space_r, space_nxt;
  logic               policy_r, policy_nxt;
  logic [STAMP_W-1:0] stamp_cnt_r, stamp_cnt_nxt;
  logic [IDX_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic [STAMP_W-1:0] best_stamp_r, best_stamp_nxt;
  logic               found_r, found_nxt;
  cmp_mode_t          mode_r, mode_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [IDX_W-1:0]   res_slot_r, res_slot_nxt;
  logic [PAGE_W-1:0]  res_page_r, res_page_nxt;
  logic [SPACE_W-1:0] res_space_r, res_space_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [PAGE_W-1:0]  out_page_r, out_page_nxt;
  logic [SPACE_W-1:0] out_space_r, out_space_nxt;

  store_op_t          op;
  logic [IDX_W-1:0]   rd_idx;
  logic [PAGE_W-1:0]  rd_page;
  logic [SPACE_W-1:0] rd_space;
  logic [STAMP_W-1:0] rd_stamp;
  logic [SLOTS-1:0]   used;
  logic [SLOTS-1:0]   accessed;
  logic               take;
  logic [IDX_W-1:0]   free_idx;
  logic [STAMP_W-1:0] stamp_inc;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign stamp_inc = stamp_cnt_r + STAMP_W'(1);
  // address the store with the next index so the registered read word lines up with the slot in use
  assign rd_idx    = (state_nxt == S_EVICT) ? best_idx_nxt : scan_idx_nxt;

  prt_slot_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .wr_page  (page_r),
    .wr_space (space_r),
    .rd_idx   (rd_idx),
    .rd_page  (rd_page),
    .rd_space (rd_space),
    .rd_stamp (rd_stamp),
    .used     (used),
    .accessed (accessed)
  );

  prt_cmp_unit u_cmp (
    .mode        (mode_r),
    .entry_used  (used[scan_idx_r]),
    .entry_stamp (rd_stamp),
    .best_stamp  (best_stamp_r),
    .found       (found_r),
    .entry_page  (rd_page),
    .entry_space (rd_space),
    .key_page    (page_r),
    .key_space   (space_r),
    .take        (take)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    page_nxt       = page_r;
    space_nxt      = space_r;
    policy_nxt     = cfg_valid ? cfg_data[0] : policy_r;
    stamp_cnt_nxt  = stamp_cnt_r;
    scan_idx_nxt   = scan_idx_r;
    best_idx_nxt   = best_idx_r;
    best_stamp_nxt = best_stamp_r;
    found_nxt      = found_r;
    mode_nxt       = mode_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_page_nxt   = res_page_r;
    res_space_nxt  = res_space_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_page_nxt   = out_page_r;
    out_space_nxt  = out_space_r;
    op             = '0;

    case (state_r)
      // take a new word
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_command;
          page_nxt  = in_page_number;
          space_nxt = in_space_id;
          state_nxt = S_DECODE;
        end
      end

      // dispatch the command
      S_DECODE: begin
        res_page_nxt  = '0;
        res_space_nxt = '0;
        scan_idx_nxt  = '0;
        found_nxt     = 1'b0;
        case (cmd_r)
          CMD_INSERT: begin
            if (!(&used)) begin
              op.ins         = 1'b1;
              op.idx         = free_idx;
              op.stamp       = stamp_inc;
              stamp_cnt_nxt  = stamp_inc;
              res_status_nxt = ST_INS_FREE;
              res_slot_nxt   = free_idx;
              state_nxt      = S_RESP;
            end else begin
              mode_nxt  = policy_r ? CMP_FIFO : CMP_LIFO;
              state_nxt = S_SCAN;
            end
          end
          CMD_TOUCH, CMD_REMOVE: begin
            mode_nxt  = CMP_MATCH;
            state_nxt = S_SCAN;
          end
          default: begin
            res_status_nxt = ST_NO_MATCH;
            res_slot_nxt   = '0;
            state_nxt      = S_RESP;
          end
        endcase
      end

      // visit one slot per cycle
      S_SCAN: begin
        if (take) begin
          if (mode_r == CMP_MATCH) begin
            if (!found_r) begin
              best_idx_nxt = scan_idx_r;
            end
            op.touch = (cmd_r == CMD_TOUCH);
            op.drop  = (cmd_r == CMD_REMOVE);
            op.idx   = scan_idx_r;
          end else begin
            best_idx_nxt   = scan_idx_r;
            best_stamp_nxt = rd_stamp;
          end
          found_nxt = 1'b1;
        end
        if (scan_idx_r == LAST_IDX) begin
          if (mode_r == CMP_MATCH) begin
            if (found_nxt) begin
              res_status_nxt = (cmd_r == CMD_TOUCH) ? ST_TOUCHED : ST_REMOVED;
              res_slot_nxt   = best_idx_nxt;
            end else begin
              res_status_nxt = ST_NO_MATCH;
              res_slot_nxt   = '0;
            end
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_CHECK;
          end
        end else begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
        end
      end

      // give a second chance or settle the victim
      S_CHECK: begin
        if (mode_r == CMP_FIFO && accessed[best_idx_r]) begin
          op.restamp    = 1'b1;
          op.idx        = best_idx_r;
          op.stamp      = stamp_inc;
          stamp_cnt_nxt = stamp_inc;
          scan_idx_nxt  = '0;
          found_nxt     = 1'b0;
          state_nxt     = S_SCAN;
        end else begin
          state_nxt = S_EVICT;
        end
      end

      // report the victim and reuse its slot
      S_EVICT: begin
        res_page_nxt   = rd_page;
        res_space_nxt  = rd_space;
        op.ins         = 1'b1;
        op.idx         = best_idx_r;
        op.stamp       = stamp_inc;
        stamp_cnt_nxt  = stamp_inc;
        res_status_nxt = ST_INS_EVICT;
        res_slot_nxt   = best_idx_r;
        state_nxt      = S_RESP;
      end

      // move the result into the output register once it is free
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = SLOT_W'(res_slot_r);
          out_page_nxt   = res_page_r;
          out_space_nxt  = res_space_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= 1'b1;
      stamp_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      policy_r    <= policy_nxt;
      stamp_cnt_r <= stamp_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    page_r       <= page_nxt;
    space_r      <= space_nxt;
    scan_idx_r   <= scan_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_stamp_r <= best_stamp_nxt;
    found_r      <= found_nxt;
    mode_r       <= mode_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_page_r   <= res_page_nxt;
    res_space_r  <= res_space_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_page_r   <= out_page_nxt;
    out_space_r  <= out_space_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot          = out_slot_r;
  assign out_evicted_page  = out_page_r;
  assign out_evicted_space = out_space_r;

  // busy right after an accepted word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // eviction only happens with every slot in use
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVICT |-> (&used))
    else $error("eviction with a free slot");

  // a free insert reports no victim
  a_free_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_INS_FREE |-> out_evicted_page == '0 &&
      out_evicted_space == '0)
    else $error("free insert reports a victim");

  // stamp counter moves only by one
  a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && stamp_cnt_r != $past(stamp_cnt_r) |->
      stamp_cnt_r == STAMP_W'($past(stamp_cnt_r) + STAMP_W'(1)))
    else $error("stamp counter jumped");

endmodule
